// ----- rtl/core/sbt_pkg.sv -----
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, constants and alphabet lookups for the six-bit text codec.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int CODE_BITS     = 6;
    localparam int BYTE_BITS     = 8;
    localparam int ALPHABET_SIZE = 46;

    // pending bits kept between transactions never exceed seven
    localparam int HOLD_BITS  = 7;
    localparam int HOLD_CNT_W = 3;

    // working accumulator inside one transaction
    localparam int WIDE_BITS = 16;
    localparam int CNT_W     = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    typedef enum logic {
        DIR_PACK   = 1'b0,
        DIR_UNPACK = 1'b1
    } dir_t;

    typedef logic [CODE_BITS-1:0] code_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       bad_symbol;
        logic       end_of_message;
    } res_t;

    typedef struct packed {
        logic [1:0]           n;
        res_t                 res0;
        res_t                 res1;
        logic [WIDE_BITS-1:0] buf_wide;
        logic [CNT_W-1:0]     count_wide;
        logic                 err;
    } codec_out_t;

    localparam logic [7:0] GLYPHS [ALPHABET_SIZE] = '{
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p",
        "a", "s", "d", "f", "g", "h", "j", "k", "l",
        "z", "x", "c", "v", "b", "n", "m",
        ",", ".", "_", "?", "!", " ",
        "+", "-", "*", "/",
        "0", "1", "2", "3", "4", "5", "6", "7", "8", "9"
    };

    // returns {found, code}
    function automatic logic [CODE_BITS:0] char_to_code(input logic [7:0] ch);
        logic  found;
        code_t code;
        found = 1'b0;
        code  = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (GLYPHS[i] == ch) begin
                found = 1'b1;
                code  = CODE_BITS'(i);
            end
        end
        return {found, code};
    endfunction

    // unused codes map to zero
    function automatic logic [7:0] code_to_char(input code_t code);
        logic [7:0] ch;
        ch = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (code == CODE_BITS'(i)) begin
                ch = GLYPHS[i];
            end
        end
        return ch;
    endfunction

endpackage

// ----- rtl/core/sbt_codec.sv -----
// ----------------------------------------------------------------------------
// sbt_codec
// Single-pass datapath: merges one transaction into the pending bits and
// produces up to two results plus the updated accumulator.
// ----------------------------------------------------------------------------
module sbt_codec (
    input  sbt_pkg::dir_t                     direction,
    input  logic [7:0]                        data_byte,
    input  logic                              last_item,
    input  logic [sbt_pkg::HOLD_BITS-1:0]     hold_buf,
    input  logic [sbt_pkg::HOLD_CNT_W-1:0]    hold_cnt,
    input  logic                              err_in,
    output sbt_pkg::codec_out_t               result
);
    import sbt_pkg::*;

    logic [CODE_BITS:0]   lookup;
    logic [WIDE_BITS-1:0] acc;
    logic [WIDE_BITS-1:0] acc_shift;
    logic [CNT_W-1:0]     cnt;
    logic [CNT_W-1:0]     rem;
    code_t                code0;
    code_t                code1;
    logic                 bad0;
    logic                 bad1;
    logic                 err;
    logic [1:0]           n;
    logic [7:0]           val0;
    logic [7:0]           val1;
    logic [WIDE_BITS-1:0] rbuf;
    logic [CNT_W-1:0]     rcnt;

    always_comb begin
        lookup    = char_to_code(data_byte);
        acc       = WIDE_BITS'(hold_buf);
        cnt       = CNT_W'(hold_cnt);
        acc_shift = '0;
        rem       = '0;
        code0     = '0;
        code1     = '0;
        bad0      = 1'b0;
        bad1      = 1'b0;
        err       = err_in;
        n         = 2'd0;
        val0      = '0;
        val1      = '0;
        rbuf      = '0;
        rcnt      = '0;

        case (direction)
            DIR_PACK: begin
                if (lookup[CODE_BITS]) begin
                    acc = acc | (WIDE_BITS'(lookup[CODE_BITS-1:0]) << hold_cnt);
                    cnt = cnt + CNT_W'(CODE_BITS);
                end else begin
                    err = 1'b1;
                end
                acc_shift = acc >> BYTE_BITS;
                rem       = cnt - CNT_W'(BYTE_BITS);
                rbuf      = acc;
                rcnt      = cnt;
                val0      = acc[7:0];
                val1      = acc_shift[7:0];
                if (cnt >= CNT_W'(BYTE_BITS)) begin
                    n    = 2'd1;
                    rbuf = acc_shift;
                    rcnt = rem;
                    if (rem >= CNT_W'(BYTE_BITS)) begin
                        n    = 2'd2;
                        rbuf = acc_shift >> BYTE_BITS;
                        rcnt = rem - CNT_W'(BYTE_BITS);
                    end else if (last_item && rem != '0) begin
                        n = 2'd2;
                    end
                end else if (last_item && cnt != '0) begin
                    n = 2'd1;
                end
            end
            DIR_UNPACK: begin
                acc   = acc | (WIDE_BITS'(data_byte) << hold_cnt);
                cnt   = cnt + CNT_W'(BYTE_BITS);
                code0 = acc[CODE_BITS-1:0];
                code1 = acc[2*CODE_BITS-1:CODE_BITS];
                bad0  = code0 >= CODE_BITS'(ALPHABET_SIZE);
                bad1  = code1 >= CODE_BITS'(ALPHABET_SIZE);
                val0  = code_to_char(code0);
                val1  = code_to_char(code1);
                rbuf  = acc;
                rcnt  = cnt;
                if (cnt >= CNT_W'(2 * CODE_BITS)) begin
                    n    = 2'd2;
                    err  = err | bad0 | bad1;
                    rbuf = acc >> (2 * CODE_BITS);
                    rcnt = cnt - CNT_W'(2 * CODE_BITS);
                end else if (cnt >= CNT_W'(CODE_BITS)) begin
                    n    = 2'd1;
                    err  = err | bad0;
                    rbuf = acc >> CODE_BITS;
                    rcnt = cnt - CNT_W'(CODE_BITS);
                end
            end
            default: begin
                n = 2'd0;
            end
        endcase

        result.n                   = n;
        result.res0.out_byte       = val0;
        result.res0.bad_symbol     = err;
        result.res0.end_of_message = last_item && (n == 2'd1);
        result.res1.out_byte       = val1;
        result.res1.bad_symbol     = err;
        result.res1.end_of_message = last_item && (n == 2'd2);
        result.buf_wide            = rbuf;
        result.count_wide          = rcnt;
        result.err                 = err;
    end

endmodule

// ----- rtl/core/sbt_result_fifo.sv -----
// ----------------------------------------------------------------------------
// sbt_result_fifo
// Small result queue: takes up to two results per cycle, drains one per
// output transaction.
// ----------------------------------------------------------------------------
module sbt_result_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_n,
    input  sbt_pkg::res_t push0,
    input  sbt_pkg::res_t push1,
    output logic          room,
    output logic          m_valid,
    input  logic          m_ready,
    output sbt_pkg::res_t m_res
);
    import sbt_pkg::*;

    res_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg;
    logic [FIFO_PTR_W:0]   count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic                  pop;

    assign m_valid      = count_reg != '0;
    assign m_res        = mem_reg[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign room         = count_reg <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2);
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + (FIFO_PTR_W+1)'(push_n) - (FIFO_PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/sixbit_text_pack_unpack_core.sv -----
// ----------------------------------------------------------------------------
// sixbit_text_pack_unpack_core
// Six-bit text codec: packs alphabet characters into bytes or unpacks bytes
// back into characters.
// Path: a result reaches the m_ side through the input register, then the
// result queue.
// Throughput: one input transaction per cycle while items give at most one
// result each and m_tready is held high; items that give two results are
// throttled by the single-result output port draining the result queue.
// Reset: synchronous, clears pending bits, error flag, direction and queue.
// ----------------------------------------------------------------------------
module sixbit_text_pack_unpack_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,     // direction
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] data_byte
    input  logic       s_tlast,       // last_item
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] out_byte
    output logic [0:0] m_tuser,       // [0] bad_symbol
    output logic       m_tlast        // end_of_message
);
    import sbt_pkg::*;

    dir_t                  direction_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_data_reg;
    logic                  in_last_reg;
    logic [HOLD_BITS-1:0]  bit_buffer_reg;
    logic [HOLD_CNT_W-1:0] bit_count_reg;
    logic                  error_seen_reg;
    codec_out_t            codec_out;
    logic                  room;
    logic                  fire;
    logic                  s_accept;
    logic [1:0]            push_n;
    res_t                  m_res;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;
    assign push_n   = fire ? codec_out.n : 2'd0;

    sbt_codec u_codec (
        .direction (direction_reg),
        .data_byte (in_data_reg),
        .last_item (in_last_reg),
        .hold_buf  (bit_buffer_reg),
        .hold_cnt  (bit_count_reg),
        .err_in    (error_seen_reg),
        .result    (codec_out)
    );

    sbt_result_fifo u_result_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .push0   (codec_out.res0),
        .push1   (codec_out.res1),
        .room    (room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    assign m_tdata    = m_res.out_byte;
    assign m_tuser[0] = m_res.bad_symbol;
    assign m_tlast    = m_res.end_of_message;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg  <= DIR_PACK;
            in_valid_reg   <= 1'b0;
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            error_seen_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                direction_reg <= dir_t'(cfg_wdata);
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                error_seen_reg <= codec_out.err;
                if (in_last_reg) begin
                    bit_buffer_reg <= '0;
                    bit_count_reg  <= '0;
                end else begin
                    bit_buffer_reg <= codec_out.buf_wide[HOLD_BITS-1:0];
                    bit_count_reg  <= codec_out.count_wide[HOLD_CNT_W-1:0];
                end
            end
        end
    end

    // pending bits left behind must fit the hold register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !in_last_reg) |-> (codec_out.count_wide < CNT_W'(1 << HOLD_CNT_W)))
        else $error("pending bit count exceeds hold register");

    // a message end leaves nothing pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_last_reg) |=> (bit_count_reg == '0))
        else $error("pending bits remain after message end");

    // error flag stays set on later results
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser[0]) |=> (!m_tvalid || m_tuser[0]))
        else $error("sticky error flag dropped");

    // an item never leaves its input stage while the queue has no room
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !room) |=> in_valid_reg)
        else $error("input stage lost an item");

endmodule
